[hw/rtl/b64d_pkg.sv]
`timescale 1ns / 1ps

package b64d_pkg;

  // Depth of the job queue between the front and the back part.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Symbol counts that matter when a partial group is flushed.
  localparam logic [1:0] CountOne   = 2'd1;
  localparam logic [1:0] CountTwo   = 2'd2;
  localparam logic [1:0] CountThree = 2'd3;

  // Byte slots inside one job.
  localparam logic [1:0] SlotFirst  = 2'd0;
  localparam logic [1:0] SlotSecond = 2'd1;
  localparam logic [1:0] SlotThird  = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } out_item_t;

  // Result of classifying one character.
  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sym_t;

  // Work handed from the front to the back: up to three bytes of one item.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] nbytes;
    logic       last;
  } job_t;

  // Maps a character of the standard alphabet to its 6-bit value.
  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t s;
    s.ok    = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      s.value = 6'd62;
    end else if (c == 8'h2f) begin
      s.value = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

[hw/rtl/b64d_front.sv]
`timescale 1ns / 1ps

module b64d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  b64d_pkg::in_item_t in_data_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output b64d_pkg::job_t     job_o
);

  logic [17:0]     group_bits_q, group_bits_d;
  logic [1:0]      symbol_count_q, symbol_count_d;
  logic            stopped_q, stopped_d;
  logic            accept;
  b64d_pkg::sym_t  sym;
  logic [17:0]     bits_upd;
  logic [1:0]      count_upd;
  logic [23:0]     word;
  logic [17:0]     flush_bits;
  logic [1:0]      flush_cnt;
  logic            do_flush;
  b64d_pkg::job_t  job;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign sym        = b64d_pkg::sym_lookup(in_data_i.char_code);
  assign bits_upd   = {group_bits_q[11:0], sym.value};
  assign count_upd  = symbol_count_q + 2'd1;
  assign word       = {group_bits_q, sym.value};

  always_comb begin
    group_bits_d   = group_bits_q;
    symbol_count_d = symbol_count_q;
    stopped_d      = stopped_q;
    flush_bits     = group_bits_q;
    flush_cnt      = symbol_count_q;
    do_flush       = 1'b0;
    job            = '0;
    job.last       = in_data_i.end_of_text;
    if (accept) begin
      if (!stopped_q) begin
        if (!sym.ok) begin
          // Pad or stray character: flush what was collected and stop.
          do_flush       = 1'b1;
          stopped_d      = 1'b1;
          group_bits_d   = '0;
          symbol_count_d = '0;
        end else if (symbol_count_q == b64d_pkg::CountThree) begin
          job.byte0      = word[23:16];
          job.byte1      = word[15:8];
          job.byte2      = word[7:0];
          job.nbytes     = 2'd3;
          group_bits_d   = '0;
          symbol_count_d = '0;
        end else begin
          group_bits_d   = bits_upd;
          symbol_count_d = count_upd;
          flush_bits     = bits_upd;
          flush_cnt      = count_upd;
          do_flush       = in_data_i.end_of_text;
        end
      end
      if (in_data_i.end_of_text) begin
        group_bits_d   = '0;
        symbol_count_d = '0;
        stopped_d      = 1'b0;
      end
    end
    if (do_flush) begin
      case (flush_cnt)
        b64d_pkg::CountTwo: begin
          job.byte0  = flush_bits[11:4];
          job.nbytes = 2'd1;
        end
        b64d_pkg::CountThree: begin
          job.byte0  = flush_bits[17:10];
          job.byte1  = flush_bits[9:2];
          job.nbytes = 2'd2;
        end
        default: begin
          // Nothing or a single symbol: no byte comes out.
          job.nbytes = 2'd0;
        end
      endcase
    end
  end

  assign push_o = accept && (job.nbytes != 2'd0 || in_data_i.end_of_text);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_bits_q   <= '0;
      symbol_count_q <= '0;
      stopped_q      <= 1'b0;
    end else begin
      group_bits_q   <= group_bits_d;
      symbol_count_q <= symbol_count_d;
      stopped_q      <= stopped_d;
    end
  end

  // The end of a string always leaves the decoder re-armed.
  a_eot_rearm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_text |=> symbol_count_q == 2'd0 && !stopped_q
      && group_bits_q == 18'd0)
    else $error("decoder not re-armed after end of string");

  // An empty job is only queued to carry the end-of-string mark.
  a_empty_job_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.nbytes == 2'd0 |-> job_o.last)
    else $error("empty job queued without last");

endmodule

[hw/rtl/b64d_fifo.sv]
`timescale 1ns / 1ps

module b64d_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output b64d_pkg::job_t head_o
);

  b64d_pkg::job_t                       mem_q [b64d_pkg::FifoDepth];
  logic [b64d_pkg::FifoPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [b64d_pkg::FifoPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [b64d_pkg::FifoCntW-1:0]        count_q, count_d;

  assign full_o       = count_q == b64d_pkg::FifoCntW'(b64d_pkg::FifoDepth);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into a full job queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from an empty job queue");

endmodule

[hw/rtl/b64d_back.sv]
`timescale 1ns / 1ps

module b64d_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  b64d_pkg::job_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64d_pkg::out_item_t out_data_o
);

  logic                out_valid_q, out_valid_d;
  b64d_pkg::out_item_t out_q, out_d;
  logic [1:0]          slot_q, slot_d;
  logic [1:0]          final_slot;
  logic                load_en;
  logic                at_final;
  logic [7:0]          sel_byte;

  assign final_slot = (head_i.nbytes == 2'd0) ? 2'd0 : head_i.nbytes - 2'd1;
  assign at_final   = slot_q == final_slot;
  assign load_en    = !out_valid_q || !out_stall_i;
  assign pop_o      = load_en && head_valid_i && at_final;

  always_comb begin
    case (slot_q)
      b64d_pkg::SlotFirst:  sel_byte = head_i.byte0;
      b64d_pkg::SlotSecond: sel_byte = head_i.byte1;
      b64d_pkg::SlotThird:  sel_byte = head_i.byte2;
      default:              sel_byte = 8'd0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    slot_d      = slot_q;
    if (load_en) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        out_d.byte_valid = head_i.nbytes != 2'd0;
        out_d.data_byte  = (head_i.nbytes != 2'd0) ? sel_byte : 8'd0;
        out_d.last       = head_i.last && at_final;
        slot_d           = at_final ? 2'd0 : slot_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      slot_q      <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A beat without a byte exists only to close a string, and carries zero.
  a_empty_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.last
      && out_data_o.data_byte == 8'd0)
    else $error("empty beat without last or with data");

  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> slot_q <= final_slot)
    else $error("byte slot past the end of the job");

endmodule

[hw/rtl/base64_stream_decoder.sv]
`timescale 1ns / 1ps

// Streaming base64 decoder. The input channel takes one character per beat
// with an end_of_text flag on the last character of a string. The output
// channel gives one decoded byte per beat; byte_valid tells whether the beat
// carries a byte and last marks the final beat of a string. A string whose
// end produces no byte still gives one beat with byte_valid low and last set.
// Both channels use valid/stall: a beat moves on a rising edge with valid
// high and stall low.
// The front part classifies each character and assembles groups in the same
// cycle it is accepted, queuing a job of up to three bytes. The back part
// drains jobs into the output register one byte per cycle while the receiver
// does not stall. Input accepts one character per cycle while the queue is
// not full; output gives one beat per cycle while not stalled, which sustains
// the stream because four characters yield only three bytes. A burst of
// short items is absorbed by the four-entry job queue.
// When the receiver stalls, the output beat holds and the queue fills; once
// it is full, in_stall_o rises. Reset clears the group state, the queue and
// the output valid flag; no result is pending afterward.
module base64_stream_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b64d_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64d_pkg::out_item_t out_data_o
);

  logic           fifo_full;
  logic           push;
  b64d_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  b64d_pkg::job_t head_job;

  // Character classification and group assembly.
  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Short queue that decouples the two sides.
  b64d_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  // Byte serializer with the output register.
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[test/tb_base64_stream_decoder.sv]
`timescale 1ns / 1ps

// Self-checking bench for the streaming base64 decoder. Characters go in one
// beat at a time, and decoded bytes come out one beat at a time. A local model
// of the decoder predicts the beats for each accepted character. Every output
// beat is compared with the oldest expected beat.
module tb_base64_stream_decoder;

  // A beat on either side within this many cycles; otherwise the run is hung.
  localparam int unsigned QuietLimit  = 5000;
  // The output register plus a full job queue drains well inside this.
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned PhaseItems  = 75;
  localparam int unsigned MaxPrinted  = 40;
  localparam logic [7:0]  PadChar     = "=";

  localparam b64d_pkg::out_item_t NoBeat   = '0;
  localparam b64d_pkg::out_item_t EmptyEnd = {8'h00, 1'b0, 1'b1};

  // One directed character. Where typed is set, the beats listed here are
  // the expected result, and the local model is only advanced. Otherwise the
  // model supplies the expected beats.
  typedef struct packed {
    logic [7:0]          ch;
    logic                eot;
    logic                typed;
    logic [1:0]          n;
    b64d_pkg::out_item_t b0;
    b64d_pkg::out_item_t b1;
    b64d_pkg::out_item_t b2;
  } stim_row_t;

  localparam int unsigned NumRows = 22;
  localparam stim_row_t DirectedRows [0:NumRows-1] = '{
    // "TWFu" decodes to "Man", with the whole group released on the final symbol.
    '{"T", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"W", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"F", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"u", 1'b1, 1'b1, 2'd3, {8'h4d, 1'b1, 1'b0}, {8'h61, 1'b1, 1'b0},
      {8'h6e, 1'b1, 1'b1}},
    // "AA==": the first pad flushes one zero byte. The second pad is ignored,
    // so the end of the string gives an empty beat.
    '{"A", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"A", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{PadChar, 1'b0, 1'b1, 2'd1, {8'h00, 1'b1, 1'b0}, NoBeat, NoBeat},
    '{PadChar, 1'b1, 1'b1, 2'd1, EmptyEnd, NoBeat, NoBeat},
    // "//8=": symbols 63, 63 and 60 flush two 0xff bytes on a pad that ends the string.
    '{"/", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"/", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"8", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{PadChar, 1'b1, 1'b1, 2'd2, {8'hff, 1'b1, 1'b0}, {8'hff, 1'b1, 1'b1}, NoBeat},
    // A lone symbol is dropped by a stop character. What follows is ignored,
    // and a high byte ends the string.
    '{"Z", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"*", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"A", 1'b0, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat},
    '{8'hff, 1'b1, 1'b1, 2'd1, EmptyEnd, NoBeat, NoBeat},
    // A string made only of a NUL character.
    '{8'h00, 1'b1, 1'b1, 2'd1, EmptyEnd, NoBeat, NoBeat},
    // Two and three symbols flushed by the end of the string itself.
    '{"z", 1'b0, 1'b0, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"+", 1'b1, 1'b0, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"Q", 1'b0, 1'b0, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"0", 1'b0, 1'b0, 2'd0, NoBeat, NoBeat, NoBeat},
    '{"9", 1'b1, 1'b0, 2'd0, NoBeat, NoBeat, NoBeat}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  b64d_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  b64d_pkg::out_item_t out_data_o;

  base64_stream_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Local decoder state, kept apart from the bench's other variables. The model
  // runs only on characters that the block has really accepted.
  logic [17:0]         acc_bits;
  logic [1:0]          acc_count;
  logic                halted;
  b64d_pkg::out_item_t pred_beats [0:2];
  int unsigned         pred_count;

  // Expected beats, oldest first.
  b64d_pkg::out_item_t pending_beats [$];

  // Typed expectation for the character being driven now.
  logic                row_typed = 1'b0;
  int unsigned         row_count = 0;
  b64d_pkg::out_item_t row_beats [0:2];

  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_items    = 0;

  // Bit 6 of the result is set for a character outside the alphabet.
  function automatic logic [6:0] lookup_symbol(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return {1'b0, 6'(c - "A")};
    end
    if (c >= "a" && c <= "z") begin
      return {1'b0, 6'(c - "a" + 26)};
    end
    if (c >= "0" && c <= "9") begin
      return {1'b0, 6'(c - "0" + 52)};
    end
    if (c == "+") begin
      return {1'b0, 6'd62};
    end
    if (c == "/") begin
      return {1'b0, 6'd63};
    end
    return 7'h40;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    pred_beats[pred_count].data_byte  = b;
    pred_beats[pred_count].byte_valid = 1'b1;
    pred_beats[pred_count].last       = 1'b0;
    pred_count++;
  endfunction

  // A partial group of two symbols gives one byte, and three symbols give two.
  // A single symbol gives nothing.
  function automatic void flush_partial();
    if (acc_count == b64d_pkg::CountTwo) begin
      emit_byte(acc_bits[11:4]);
    end else if (acc_count == b64d_pkg::CountThree) begin
      emit_byte(acc_bits[17:10]);
      emit_byte(acc_bits[9:2]);
    end
    acc_bits  = '0;
    acc_count = '0;
  endfunction

  function automatic void predict_char(input b64d_pkg::in_item_t it);
    logic [6:0]  sym;
    logic [23:0] group;
    sym        = lookup_symbol(it.char_code);
    pred_count = 0;
    if (!halted) begin
      if (sym[6]) begin
        flush_partial();
        halted = 1'b1;
      end else if (acc_count == b64d_pkg::CountThree) begin
        group = {acc_bits, sym[5:0]};
        emit_byte(group[23:16]);
        emit_byte(group[15:8]);
        emit_byte(group[7:0]);
        acc_bits  = '0;
        acc_count = '0;
      end else begin
        acc_bits  = {acc_bits[11:0], sym[5:0]};
        acc_count = acc_count + 2'd1;
      end
    end
    // The end of the string flushes what is left and always closes with a
    // last beat, which is an empty one if nothing else came out.
    if (it.end_of_text) begin
      if (!halted) begin
        flush_partial();
      end
      if (pred_count == 0) begin
        pred_beats[0] = EmptyEnd;
        pred_count    = 1;
      end else begin
        pred_beats[pred_count-1].last = 1'b1;
      end
      acc_bits  = '0;
      acc_count = '0;
      halted    = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input b64d_pkg::out_item_t got,
                                 input b64d_pkg::out_item_t want);
    fail_count++;
    if (fail_count <= MaxPrinted) begin
      $display("%0t: %s: got byte %02h valid %b last %b, want byte %02h valid %b last %b",
               $time, what, got.data_byte, got.byte_valid, got.last,
               want.data_byte, want.byte_valid, want.last);
    end
  endtask

  task automatic check_beat(input b64d_pkg::out_item_t got);
    b64d_pkg::out_item_t want;
    if (pending_beats.size() == 0) begin
      report_mismatch("unexpected beat", got, NoBeat);
      return;
    end
    want = pending_beats.pop_front();
    if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
        got.last !== want.last) begin
      report_mismatch("beat differs", got, want);
    end
  endtask

  // The model starts in its reset state, which matches the block after reset.
  initial begin
    acc_bits   = '0;
    acc_count  = '0;
    halted     = 1'b0;
    pred_count = 0;
  end

  // All handshakes are observed on the rising edge. The inputs were set on
  // the falling edge before, and the block's outputs have not yet moved.
  // This block also runs the watchdog. Any cycle without a beat on either
  // side counts toward the limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_char(in_data_i);
        if (row_typed) begin
          for (int k = 0; k < row_count; k++) pending_beats.push_back(row_beats[k]);
        end else begin
          for (int k = 0; k < pred_count; k++) pending_beats.push_back(pred_beats[k]);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        check_beat(out_data_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // The receiver draws a new stall decision on every falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Call on a falling edge. This may idle first, then holds the beat until it
  // is taken, and returns on the next falling edge. Valid is assigned at most
  // once per falling edge.
  task automatic send_char(input b64d_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Returns a character that stops decoding. Padding is the usual one, so it
  // is chosen half the time.
  function automatic logic [7:0] stop_char();
    logic [7:0] c;
    logic [6:0] s;
    if ($urandom_range(1) == 0) return PadChar;
    do begin
      c = 8'($urandom_range(255));
      s = lookup_symbol(c);
    end while (!s[6]);
    return c;
  endfunction

  // Sends one random string. Most strings are well formed, with random
  // symbols and correct or missing padding. Some are cut short by a stray
  // stop character and followed by junk. The rest are raw byte noise.
  task automatic send_random_text();
    b64d_pkg::in_item_t text [$];
    b64d_pkg::in_item_t it;
    int unsigned        nsym;
    int unsigned        pick;
    int unsigned        cut;
    pick = $urandom_range(99);
    nsym = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(9);
    cut  = $urandom_range(nsym);
    if (pick < 90) begin
      for (int i = 0; i <= nsym; i++) begin
        if (pick >= 70 && i == cut) begin
          it = {stop_char(), 1'b0};
          text.push_back(it);
        end
        if (i < nsym) begin
          it = {char_of(6'($urandom_range(63))), 1'b0};
          text.push_back(it);
        end
      end
      if (pick < 70 && nsym % 4 != 0 && $urandom_range(3) != 0) begin
        repeat (4 - nsym % 4) text.push_back({PadChar, 1'b0});
      end
      if (pick >= 70) begin
        repeat ($urandom_range(4)) text.push_back({8'($urandom_range(255)), 1'b0});
      end
    end else begin
      repeat ($urandom_range(1, 6)) text.push_back({8'($urandom_range(255)), 1'b0});
    end
    if (text.size() == 0) begin
      text.push_back({char_of(6'($urandom_range(63))), 1'b0});
    end
    text[text.size()-1].end_of_text = 1'b1;
    foreach (text[i]) send_char(text[i]);
    phase_items += text.size();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The directed table runs with no idling on either side.
    for (int r = 0; r < NumRows; r++) begin
      row_typed    = DirectedRows[r].typed;
      row_count    = DirectedRows[r].n;
      row_beats[0] = DirectedRows[r].b0;
      row_beats[1] = DirectedRows[r].b1;
      row_beats[2] = DirectedRows[r].b2;
      send_char({DirectedRows[r].ch, DirectedRows[r].eot});
    end
    row_typed = 1'b0;

    // Random strings in four phases: a free-running stream, then a slow
    // sender, then a slow receiver, then light idling on both sides.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
      endcase
      phase_items = 0;
      while (phase_items < PhaseItems) send_random_text();
    end
    in_valid_i <= 1'b0;

    // The watchdog catches beats that never arrive. The extra cycles then
    // catch any stray beats that arrive late.
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_fifo.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
test/tb_base64_stream_decoder.sv
